// File: hdl/assert_macros.svh
// Assertion macros used by the steering controller back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LSPS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the cycle after it.
`define LSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lsps_pkg.sv
// Shared constants and types of the line sensor PID steering controller.
package lsps_pkg;

    // ADC sample width
    localparam int SAMPLE_BITS = 10;

    // Configuration register layout
    localparam int CFG_W       = 10;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_GAIN_P    = 2'd1;
    localparam logic [1:0] REG_GAIN_I    = 2'd2;
    localparam logic [1:0] REG_GAIN_D    = 2'd3;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 10'd512;

    // Queue between classifier and PID sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Datapath widths
    localparam int ERR_W   = 7;
    localparam int INT_W   = 5;
    localparam int DER_W   = 8;
    localparam int PROD_W  = 18;
    localparam int OUT_W   = 8;

    // One classified sensor word as queued for the back end
    typedef struct packed {
        logic signed [2:0] front_term;
        logic              front_lit;
        logic signed [2:0] rear_term;
    } lsps_entry_t;

endpackage

// File: hdl/lsps_front.sv
// Front end: accepts sensor words, thresholds them and forms the group terms.
module lsps_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   front_outer_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   front_inner_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   front_inner_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   front_outer_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   rear_outer_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   rear_inner_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   rear_inner_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]   rear_outer_b,
    input  logic [lsps_pkg::CFG_W-1:0]         threshold,
    input  logic                               q_full,
    output logic                               q_push,
    output lsps_pkg::lsps_entry_t              q_entry
);

    // Weighted position of a group of four, truncated toward zero
    function automatic logic signed [2:0] group_term(input logic [3:0] act);
        logic signed [3:0] sum;
        logic [2:0]        n;
        logic [2:0]        mag;
        logic [1:0]        q;
        sum = 4'sd0;
        if (act[0]) sum = sum - 4'sd3;
        if (act[1]) sum = sum - 4'sd1;
        if (act[2]) sum = sum + 4'sd1;
        if (act[3]) sum = sum + 4'sd3;
        n = {2'b00, act[0]} + {2'b00, act[1]} + {2'b00, act[2]} + {2'b00, act[3]};
        mag = (sum < 4'sd0) ? 3'(-sum) : 3'(sum);
        case (n)
            3'd1:    q = mag[1:0];
            3'd2:    q = 2'(mag >> 1);
            3'd3:    q = (mag >= 3'd3) ? 2'd1 : 2'd0;
            3'd4:    q = (mag == 3'd4) ? 2'd1 : 2'd0;
            default: q = 2'd0;
        endcase
        return (sum < 4'sd0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    logic [lsps_pkg::SAMPLE_BITS-1:0] thr;
    logic [7:0]                       act_next;
    logic [7:0]                       act_reg;
    logic                             act_valid_reg;
    logic                             accept;

    assign thr      = lsps_pkg::SAMPLE_BITS'(threshold);
    assign in_stall = act_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = act_valid_reg && !q_full;

    // Sensor activity compare
    always_comb
    begin
        act_next[0] = front_outer_a <= thr;
        act_next[1] = front_inner_a <= thr;
        act_next[2] = front_inner_b <= thr;
        act_next[3] = front_outer_b <= thr;
        act_next[4] = rear_outer_a  <= thr;
        act_next[5] = rear_inner_a  <= thr;
        act_next[6] = rear_inner_b  <= thr;
        act_next[7] = rear_outer_b  <= thr;
    end

    // Activity register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            act_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            act_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= act_next;
        end
    end

    // Group terms into the queue word
    always_comb
    begin
        q_entry.front_term = group_term(act_reg[3:0]);
        q_entry.front_lit  = |act_reg[3:0];
        q_entry.rear_term  = group_term(act_reg[7:4]);
    end

endmodule

// File: hdl/lsps_queue.sv
// Short FIFO of classified words between front end and PID sequencer.
module lsps_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lsps_pkg::lsps_entry_t push_entry,
    input  logic                  pop,
    output lsps_pkg::lsps_entry_t pop_entry,
    output logic                  full,
    output logic                  empty
);

    lsps_pkg::lsps_entry_t             mem_reg [lsps_pkg::QUEUE_DEPTH];
    logic [lsps_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [lsps_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [lsps_pkg::QCNT_W-1:0]       count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign full      = count_reg == lsps_pkg::QCNT_W'(lsps_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    function automatic logic [lsps_pkg::QPTR_W-1:0] ptr_inc(
        input logic [lsps_pkg::QPTR_W-1:0] p);
        return (p == lsps_pkg::QPTR_W'(lsps_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + lsps_pkg::QPTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + lsps_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - lsps_pkg::QCNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/lsps_back.sv
// Back end: error tracking, integral, and PID sum on a shared multiplier.
`include "assert_macros.svh"

module lsps_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  lsps_pkg::lsps_entry_t               q_entry,
    output logic                                q_pop,
    input  logic signed [lsps_pkg::CFG_W-1:0]   gain_p,
    input  logic signed [lsps_pkg::CFG_W-1:0]   gain_i,
    input  logic signed [lsps_pkg::CFG_W-1:0]   gain_d,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lsps_pkg::OUT_W-1:0]   drive_correction,
    output logic signed [lsps_pkg::ERR_W-1:0]   position_error
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM
    } state_t;

    state_t                                 state_reg;
    lsps_pkg::lsps_entry_t                  entry_reg;
    logic signed [lsps_pkg::ERR_W-1:0]      prev_error_reg;
    logic signed [lsps_pkg::INT_W-1:0]      integral_reg;
    logic signed [2:0]                      last_front_reg;
    logic signed [lsps_pkg::ERR_W-1:0]      err_reg;
    logic signed [lsps_pkg::DER_W-1:0]      deriv_reg;
    logic signed [lsps_pkg::PROD_W-1:0]     prod_reg;
    logic signed [lsps_pkg::PROD_W-1:0]     acc_reg;
    logic                                   out_valid_reg;
    logic signed [lsps_pkg::OUT_W-1:0]      drive_reg;
    logic signed [lsps_pkg::ERR_W-1:0]      pos_reg;

    logic signed [7:0]                      err_raw;
    logic signed [lsps_pkg::ERR_W-1:0]      err_next;
    logic signed [7:0]                      int_raw;
    logic signed [lsps_pkg::INT_W-1:0]      integral_next;
    logic signed [lsps_pkg::DER_W-1:0]      deriv_next;
    logic signed [lsps_pkg::CFG_W-1:0]      mul_a;
    logic signed [lsps_pkg::DER_W-1:0]      mul_b;
    logic signed [lsps_pkg::PROD_W-1:0]     prod_next;
    logic signed [lsps_pkg::PROD_W-1:0]     total;
    logic signed [lsps_pkg::OUT_W-1:0]      drive_next;
    logic                                   out_free;

    assign q_pop            = (state_reg == ST_IDLE) && !q_empty;
    assign out_free         = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign drive_correction = drive_reg;
    assign position_error   = pos_reg;

    // Error for this word; a dark front drifts toward the last front side
    always_comb
    begin
        if (entry_reg.front_lit)
        begin
            err_raw = {{5{entry_reg.front_term[2]}}, entry_reg.front_term}
                    + {{5{entry_reg.rear_term[2]}}, entry_reg.rear_term};
        end
        else if (last_front_reg < 3'sd0)
        begin
            err_raw = {prev_error_reg[6], prev_error_reg} - 8'sd1;
        end
        else if (last_front_reg > 3'sd0)
        begin
            err_raw = {prev_error_reg[6], prev_error_reg} + 8'sd1;
        end
        else
        begin
            err_raw = 8'sd0;
        end

        if (err_raw > 8'sd32)
            err_next = 7'sd32;
        else if (err_raw < -8'sd32)
            err_next = -7'sd32;
        else
            err_next = err_raw[6:0];

        int_raw = {{3{integral_reg[4]}}, integral_reg} + {err_next[6], err_next};
        if (int_raw > 8'sd10)
            integral_next = 5'sd10;
        else if (int_raw < -8'sd10)
            integral_next = -5'sd10;
        else
            integral_next = int_raw[4:0];

        deriv_next = {err_next[6], err_next} - {prev_error_reg[6], prev_error_reg};
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MUL_P:
            begin
                mul_a = gain_p;
                mul_b = {err_reg[6], err_reg};
            end
            ST_MUL_I:
            begin
                mul_a = gain_i;
                mul_b = {{3{integral_reg[4]}}, integral_reg};
            end
            ST_MUL_D:
            begin
                mul_a = gain_d;
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Final sum and output clamp
    always_comb
    begin
        total = acc_reg + prod_reg;
        if (total > 18'sd100)
            drive_next = 8'sd100;
        else if (total < -18'sd100)
            drive_next = -8'sd100;
        else
            drive_next = total[7:0];
    end

    // Sequencer, PID state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            entry_reg      <= '0;
            prev_error_reg <= '0;
            integral_reg   <= '0;
            last_front_reg <= '0;
            err_reg        <= '0;
            deriv_reg      <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            // a finished word loads the output register; an accepted one leaves it
            if (state_reg == ST_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        entry_reg <= q_entry;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR:
                begin
                    err_reg        <= err_next;
                    deriv_reg      <= deriv_next;
                    integral_reg   <= integral_next;
                    prev_error_reg <= err_next;
                    if (entry_reg.front_lit)
                    begin
                        last_front_reg <= entry_reg.front_term;
                    end
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= prod_next;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    prod_reg  <= prod_next;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        drive_reg <= drive_next;
                        pos_reg   <= err_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `LSPS_ASSERT_ALWAYS(a_integral_range, clk, rst_n,
        integral_reg >= -5'sd10 && integral_reg <= 5'sd10, "integral out of range")
    `LSPS_ASSERT_ALWAYS(a_prev_error_range, clk, rst_n,
        prev_error_reg >= -7'sd32 && prev_error_reg <= 7'sd32, "error out of range")
    `LSPS_ASSERT_NEXT(a_err_tracks_prev, clk, rst_n, state_reg == ST_ERR,
        prev_error_reg == err_reg, "previous error not updated with current error")
    `LSPS_ASSERT_NEXT(a_result_issued, clk, rst_n, state_reg == ST_SUM && out_free,
        out_valid_reg && state_reg == ST_IDLE && pos_reg == $past(err_reg),
        "finished word not presented")

endmodule

// File: hdl/line_sensor_pid_steering.sv
// Top level of the line sensor PID steering controller.
//
// Each input word holds eight ADC samples, four front and four rear. A word
// is thresholded and reduced to two group positions in the front end, queued
// in a two-entry FIFO, and then run through the PID sequencer, which shares
// one 10x8 multiplier across the P, I and D terms. With nothing ahead of it,
// a word passes the activity register and the FIFO into the sequencer, which
// steps through pop, error update, three multiplies and final sum, and it
// finishes one word before it pops the next. Results leave through an output
// register, so up to four more words (one in the sequencer, two queued, one
// in the front end) are taken in behind a result that waits. Gains and
// threshold sit on an APB port at byte addresses 0 (threshold), 4, 8, 12
// (P, I, D gains).
module line_sensor_pid_steering (
    input  logic                                clk,
    input  logic                                rst_n,
    // sensor words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    front_outer_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    front_inner_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    front_inner_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    front_outer_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    rear_outer_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    rear_inner_a,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    rear_inner_b,
    input  logic [lsps_pkg::SAMPLE_BITS-1:0]    rear_outer_b,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lsps_pkg::OUT_W-1:0]   drive_correction,
    output logic signed [lsps_pkg::ERR_W-1:0]   position_error,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsps_pkg::ADDR_W-1:0]         paddr,
    input  logic [lsps_pkg::DATA_W-1:0]         pwdata,
    output logic [lsps_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [lsps_pkg::CFG_W-1:0]         threshold_reg;
    logic signed [lsps_pkg::CFG_W-1:0]  gain_p_reg;
    logic signed [lsps_pkg::CFG_W-1:0]  gain_i_reg;
    logic signed [lsps_pkg::CFG_W-1:0]  gain_d_reg;
    logic [1:0]                         reg_idx;
    logic                               cfg_write;

    logic                               q_push;
    logic                               q_pop;
    logic                               q_full;
    logic                               q_empty;
    lsps_pkg::lsps_entry_t              push_entry;
    lsps_pkg::lsps_entry_t              pop_entry;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= lsps_pkg::THRESHOLD_RESET;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                lsps_pkg::REG_THRESHOLD: threshold_reg <= pwdata[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_P:    gain_p_reg    <= pwdata[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_I:    gain_i_reg    <= pwdata[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_D:    gain_d_reg    <= pwdata[lsps_pkg::CFG_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Register reads; gains read back sign-extended
    always_comb
    begin
        case (reg_idx)
            lsps_pkg::REG_THRESHOLD:
                prdata = {{(lsps_pkg::DATA_W-lsps_pkg::CFG_W){1'b0}}, threshold_reg};
            lsps_pkg::REG_GAIN_P:
                prdata = {{(lsps_pkg::DATA_W-lsps_pkg::CFG_W){gain_p_reg[9]}}, gain_p_reg};
            lsps_pkg::REG_GAIN_I:
                prdata = {{(lsps_pkg::DATA_W-lsps_pkg::CFG_W){gain_i_reg[9]}}, gain_i_reg};
            lsps_pkg::REG_GAIN_D:
                prdata = {{(lsps_pkg::DATA_W-lsps_pkg::CFG_W){gain_d_reg[9]}}, gain_d_reg};
            default:
                prdata = '0;
        endcase
    end

    lsps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .front_outer_a (front_outer_a),
        .front_inner_a (front_inner_a),
        .front_inner_b (front_inner_b),
        .front_outer_b (front_outer_b),
        .rear_outer_a  (rear_outer_a),
        .rear_inner_a  (rear_inner_a),
        .rear_inner_b  (rear_inner_b),
        .rear_outer_b  (rear_outer_b),
        .threshold     (threshold_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    lsps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    lsps_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_entry          (pop_entry),
        .q_pop            (q_pop),
        .gain_p           (gain_p_reg),
        .gain_i           (gain_i_reg),
        .gain_d           (gain_d_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_correction (drive_correction),
        .position_error   (position_error)
    );

endmodule

// File: test/line_sensor_pid_steering_test.sv
// Self-checking testbench for the line sensor PID steering controller.
`timescale 1ns / 100ps

module line_sensor_pid_steering_test;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int SETTLE_GAP  = 12;
    localparam int DRAIN_GAP   = 20;
    localparam int SAMPLE_MAX  = (1 << lsps_pkg::SAMPLE_BITS) - 1;

    // steering limits
    localparam int ERR_LIMIT   = 32;
    localparam int INTEG_LIMIT = 10;
    localparam int DRIVE_LIMIT = 100;

    // sensor weights within a group, outer a .. outer b
    localparam int WEIGHT [4] = '{-3, -1, 1, 3};

    typedef logic [lsps_pkg::SAMPLE_BITS-1:0] frame_t [8];

    typedef struct {
        logic signed [lsps_pkg::OUT_W-1:0] correction;
        logic signed [lsps_pkg::ERR_W-1:0] position;
    } steer_result_t;

    typedef enum int {LIT_FRAME, DARK_FRAME, NOISE_FRAME} frame_kind_t;

    // Tracks controller state and the corrections still owed by the block
    class steering_tracker;
        logic [lsps_pkg::CFG_W-1:0]        threshold;
        logic signed [lsps_pkg::CFG_W-1:0] gain_p;
        logic signed [lsps_pkg::CFG_W-1:0] gain_i;
        logic signed [lsps_pkg::CFG_W-1:0] gain_d;
        logic signed [lsps_pkg::ERR_W-1:0] prev_err;
        logic signed [lsps_pkg::INT_W-1:0] integ;
        logic signed [2:0]                 last_front;
        steer_result_t                     owed_steer [$];
        int                                errors;

        function new();
            threshold  = lsps_pkg::THRESHOLD_RESET;
            gain_p     = '0;
            gain_i     = '0;
            gain_d     = '0;
            prev_err   = '0;
            integ      = '0;
            last_front = '0;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [lsps_pkg::DATA_W-1:0] data);
            case (idx)
                lsps_pkg::REG_THRESHOLD: threshold = data[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_P:    gain_p    = data[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_I:    gain_i    = data[lsps_pkg::CFG_W-1:0];
                lsps_pkg::REG_GAIN_D:    gain_d    = data[lsps_pkg::CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // weighted mean of the active sensors of one group, toward zero
        function int group_position(frame_t f, int base, output int lit);
            int sum;
            sum = 0;
            lit = 0;
            for (int k = 0; k < 4; k++)
            begin
                if (f[base + k] <= threshold)
                begin
                    sum += WEIGHT[k];
                    lit++;
                end
            end
            return (lit == 0) ? 0 : sum / lit;
        endfunction

        function void take_frame(frame_t f);
            int front, rear, front_lit, rear_lit, err, deriv, drive;
            steer_result_t res;
            front = group_position(f, 0, front_lit);
            rear  = group_position(f, 4, rear_lit);
            // front dark: drift from the last error toward the last front side
            if (front_lit != 0)
            begin
                last_front = 3'(front);
                err = front + rear;
            end
            else if (last_front < 0)
                err = int'(prev_err) - 1;
            else if (last_front > 0)
                err = int'(prev_err) + 1;
            else
                err = 0;
            err   = clamp(err, -ERR_LIMIT, ERR_LIMIT);
            integ = lsps_pkg::INT_W'(clamp(int'(integ) + err, -INTEG_LIMIT, INTEG_LIMIT));
            deriv = err - int'(prev_err);
            drive = int'(gain_p) * err + int'(gain_i) * int'(integ)
                  + int'(gain_d) * deriv;
            drive = clamp(drive, -DRIVE_LIMIT, DRIVE_LIMIT);
            prev_err = lsps_pkg::ERR_W'(err);
            res.correction = lsps_pkg::OUT_W'(drive);
            res.position   = lsps_pkg::ERR_W'(err);
            owed_steer.push_back(res);
        endfunction

        function void check_result(logic signed [lsps_pkg::OUT_W-1:0] dc,
                                   logic signed [lsps_pkg::ERR_W-1:0] pe);
            steer_result_t want;
            if (owed_steer.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word drive_correction %0d position_error %0d",
                         $time, dc, pe);
                return;
            end
            want = owed_steer.pop_front();
            if (dc !== want.correction)
            begin
                errors++;
                $display("%0t: drive_correction expected %0d got %0d",
                         $time, want.correction, dc);
            end
            if (pe !== want.position)
            begin
                errors++;
                $display("%0t: position_error expected %0d got %0d",
                         $time, want.position, pe);
            end
        endfunction

        function int outstanding();
            return owed_steer.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  front_outer_a;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  front_inner_a;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  front_inner_b;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  front_outer_b;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  rear_outer_a;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  rear_inner_a;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  rear_inner_b;
    logic [lsps_pkg::SAMPLE_BITS-1:0]  rear_outer_b;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [lsps_pkg::OUT_W-1:0] drive_correction;
    logic signed [lsps_pkg::ERR_W-1:0] position_error;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [lsps_pkg::ADDR_W-1:0]       paddr;
    logic [lsps_pkg::DATA_W-1:0]       pwdata;
    logic [lsps_pkg::DATA_W-1:0]       prdata;
    logic                              pready;

    steering_tracker tracker;
    int tx_max;
    int rx_max;
    int cur_threshold;
    int cycle_count;

    line_sensor_pid_steering DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .front_outer_a    (front_outer_a),
        .front_inner_a    (front_inner_a),
        .front_inner_b    (front_inner_b),
        .front_outer_b    (front_outer_b),
        .rear_outer_a     (rear_outer_a),
        .rear_inner_a     (rear_inner_a),
        .rear_inner_b     (rear_inner_b),
        .rear_outer_b     (rear_outer_b),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_correction (drive_correction),
        .position_error   (position_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // APB register write: setup then access
    task automatic write_reg(input logic [1:0] idx,
                             input logic [lsps_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // program all four registers; junk fills the unused upper bits
    task automatic configure(input int thr, input int gp, input int gi, input int gd,
                             input bit junk);
        logic [lsps_pkg::DATA_W-1:0] pad;
        pad = junk ? $urandom() : '0;
        write_reg(lsps_pkg::REG_THRESHOLD,
                  {pad[lsps_pkg::DATA_W-1:lsps_pkg::CFG_W], lsps_pkg::CFG_W'(thr)});
        pad = junk ? $urandom() : '0;
        write_reg(lsps_pkg::REG_GAIN_P,
                  {pad[lsps_pkg::DATA_W-1:lsps_pkg::CFG_W], lsps_pkg::CFG_W'(gp)});
        pad = junk ? $urandom() : '0;
        write_reg(lsps_pkg::REG_GAIN_I,
                  {pad[lsps_pkg::DATA_W-1:lsps_pkg::CFG_W], lsps_pkg::CFG_W'(gi)});
        pad = junk ? $urandom() : '0;
        write_reg(lsps_pkg::REG_GAIN_D,
                  {pad[lsps_pkg::DATA_W-1:lsps_pkg::CFG_W], lsps_pkg::CFG_W'(gd)});
        cur_threshold = thr;
    endtask

    // send one sensor word after a random gap
    task automatic send_word(input frame_t f);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        front_outer_a <= f[0];
        front_inner_a <= f[1];
        front_inner_b <= f[2];
        front_outer_b <= f[3];
        rear_outer_a  <= f[4];
        rear_inner_a  <= f[5];
        rear_inner_b  <= f[6];
        rear_outer_b  <= f[7];
        do @(posedge clk); while (in_stall);
        tracker.take_frame(f);
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    // bit k of mask active: sensor k gets lo, else hi
    function automatic frame_t mask_frame(input logic [7:0] mask, input int lo, input int hi);
        frame_t f;
        for (int k = 0; k < 8; k++)
            f[k] = mask[k] ? lsps_pkg::SAMPLE_BITS'(lo) : lsps_pkg::SAMPLE_BITS'(hi);
        return f;
    endfunction

    // random frame around the current threshold
    function automatic frame_t make_frame(input frame_kind_t kind, input int thr);
        frame_t f;
        bit lit;
        int density;
        density = $urandom_range(1, 3);
        for (int k = 0; k < 8; k++)
        begin
            if (kind == NOISE_FRAME)
                f[k] = lsps_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
            else
            begin
                if (kind == DARK_FRAME && k < 4)
                    lit = 1'b0;
                else
                    lit = ($urandom_range(0, 3) < density);
                if (thr >= SAMPLE_MAX)
                    lit = 1'b1;
                f[k] = lit ? lsps_pkg::SAMPLE_BITS'($urandom_range(0, thr))
                           : lsps_pkg::SAMPLE_BITS'($urandom_range(thr + 1, SAMPLE_MAX));
            end
        end
        return f;
    endfunction

    // result side: random stall per word, then accept and check
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = $urandom_range(0, rx_max);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            tracker.check_result(drive_correction, position_error);
        end
    end

    // main sequence
    initial
    begin
        logic [7:0] directed_masks [20];
        int sent, pick, run;
        frame_kind_t kind;

        tracker       = new();
        tx_max        = 4;
        rx_max        = 4;
        cur_threshold = lsps_pkg::THRESHOLD_RESET;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        front_outer_a = '0;
        front_inner_a = '0;
        front_inner_b = '0;
        front_outer_b = '0;
        rear_outer_a  = '0;
        rear_inner_a  = '0;
        rear_inner_b  = '0;
        rear_outer_b  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (RESET_TICKS) @(negedge clk);
        rst_n <= 1'b1;

        // directed: all lit, all dark, single edges, drift while dark,
        // truncation toward zero, rear dark, dark front with lit rear
        directed_masks = '{8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h88, 8'h00, 8'hC3,
                           8'h77, 8'hDB, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h0F, 8'hF0,
                           8'h08, 8'hF8, 8'h11, 8'h00};
        configure(lsps_pkg::THRESHOLD_RESET, 3, 2, -1, 1'b0);
        foreach (directed_masks[n])
            send_word(mask_frame(directed_masks[n], 0, SAMPLE_MAX));
        // samples right at and just above the threshold
        send_word(mask_frame(8'h5A, lsps_pkg::THRESHOLD_RESET,
                             lsps_pkg::THRESHOLD_RESET + 1));
        send_word(mask_frame(8'hA5, lsps_pkg::THRESHOLD_RESET,
                             lsps_pkg::THRESHOLD_RESET + 1));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: configure(0, 511, -512, 511, 1'b0);
                1: configure(SAMPLE_MAX, -512, 511, -512, 1'b1);
                2: configure(lsps_pkg::THRESHOLD_RESET, 1, 0, 0, 1'b0);
                3: configure($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                             $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                             1'b1);
                4: configure($urandom_range(300, 700), $urandom_range(0, 8) - 4,
                             $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, 1'b1);
                5: configure($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 24) - 12,
                             $urandom_range(0, 24) - 12, $urandom_range(0, 24) - 12, 1'b0);
                6: configure($urandom_range(1, SAMPLE_MAX - 1), $urandom_range(0, 8) - 4,
                             $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, 1'b1);
                default: configure(lsps_pkg::THRESHOLD_RESET, 0, 1, 0, 1'b0);
            endcase
            // some phases run without gaps or stalls
            tx_max = (phase % 3 == 1) ? 0 : 4;
            rx_max = (phase % 4 == 2) ? 0 : 4;

            // runs of tracked frames, dark stretches and noise
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    kind = LIT_FRAME;
                    run  = $urandom_range(1, 8);
                end
                else if (pick < 9)
                begin
                    kind = DARK_FRAME;
                    run  = $urandom_range(1, 36);
                end
                else
                begin
                    kind = NOISE_FRAME;
                    run  = $urandom_range(1, 4);
                end
                repeat (run)
                begin
                    send_word(make_frame(kind, cur_threshold));
                    sent++;
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain and watch for stray words
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);

        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
